@@ design/wlr_pkg.sv @@
// Shared layout mode codes for the wallpaper layout rectangle core.
package wlr_pkg;

    localparam int MODE_BITS = 3;

    localparam logic [MODE_BITS-1:0] MODE_CENTER  = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_FIT     = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_TILE    = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_STRETCH = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_FILL    = 3'd4;

endpackage

@@ design/wallpaper_layout_rectangles_core.sv @@
// Wallpaper layout rectangle core: crop and placement rectangles per layout mode.
// Throughput: one word per cycle unless the output is held by back-pressure; the fill crop uses
// a restoring divider, up to two quotient bits per stage, each stage holding independently on stall.
// Reset (aresetn low, synchronous) clears all stage valid bits and the output valid.
module wallpaper_layout_rectangles_core #(
    parameter int COORD_BITS = 14
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // mode, image_width, image_height, screen_width, screen_height, zero pad
    input  logic [((wlr_pkg::MODE_BITS+4*COORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // src_left, src_top, src_right, src_bottom, dst_left, dst_top, dst_right, dst_bottom
    output logic [8*COORD_BITS+7:0]                     m_tdata
);
    import wlr_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int DW    = CB + 2;
    localparam int PW    = 2 * CB;
    localparam int RW    = 2 * CB + 1;
    localparam int DSTG  = (CB + 1) / 2;
    localparam int NS    = 3 + DSTG;

    typedef struct packed {
        logic [MODE_BITS-1:0] mode;
        logic [CB-1:0]        iw;
        logic [CB-1:0]        ih;
        logic [CB-1:0]        sw;
        logic [CB-1:0]        sh;
        logic [PW-1:0]        p1;
        logic [PW-1:0]        p2;
        logic                 taller;
        logic                 dz;
        logic [RW-1:0]        rem;
        logic [CB-1:0]        den;
        logic [CB-1:0]        quo;
    } stage_t;

    stage_t        st_reg  [NS];
    stage_t        st_next [NS];
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;
    logic          out_en;

    logic                 m_valid_reg;
    logic [8*CB+7:0]      m_data_reg;
    logic [8*CB+7:0]      m_data_next;

    assign out_en   = !m_valid_reg || m_tready;
    assign s_tready = en[0];
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    genvar gi;
    generate
        for (gi = 0; gi < NS; gi++) begin : g_en
            if (gi == NS - 1) begin : g_last
                assign en[gi] = !vld_reg[gi] || out_en;
            end else begin : g_mid
                assign en[gi] = !vld_reg[gi] || en[gi+1];
            end
        end
    endgenerate

    // capture the input word
    always_comb begin
        st_next[0]        = '0;
        st_next[0].mode   = s_tdata[MODE_BITS-1:0];
        st_next[0].iw     = s_tdata[MODE_BITS +: CB];
        st_next[0].ih     = s_tdata[MODE_BITS+CB +: CB];
        st_next[0].sw     = s_tdata[MODE_BITS+2*CB +: CB];
        st_next[0].sh     = s_tdata[MODE_BITS+3*CB +: CB];
    end

    // cross products for the aspect test
    always_comb begin
        st_next[1]    = st_reg[0];
        st_next[1].p1 = PW'(st_reg[0].ih) * PW'(st_reg[0].sw);
        st_next[1].p2 = PW'(st_reg[0].sh) * PW'(st_reg[0].iw);
    end

    // pick the divide operands; bias the numerator for a ceiling quotient
    always_comb begin
        st_next[2]        = st_reg[1];
        st_next[2].taller = st_reg[1].p1 > st_reg[1].p2;
        st_next[2].den    = st_next[2].taller ? st_reg[1].sw : st_reg[1].sh;
        st_next[2].dz     = (st_next[2].den == '0);
        st_next[2].rem    = (st_next[2].taller ? {1'b0, st_reg[1].p2} : {1'b0, st_reg[1].p1})
                            + RW'(st_next[2].den) - RW'(1);
        st_next[2].quo    = '0;
    end

    generate
        for (gi = 0; gi < DSTG; gi++) begin : g_div
            localparam int K0 = CB - 1 - 2 * gi;
            localparam int K1 = CB - 2 - 2 * gi;
            stage_t        a;
            logic [RW-1:0] r1;
            logic [RW-1:0] d0;
            logic [RW-1:0] d1;
            always_comb begin
                a  = st_reg[2+gi];
                d0 = RW'(a.den) << K0;
                r1 = a.rem;
                if (r1 >= d0) begin
                    r1       = r1 - d0;
                    a.quo[K0] = 1'b1;
                end
                if (K1 >= 0) begin
                    d1 = RW'(a.den) << ((K1 >= 0) ? K1 : 0);
                    if (r1 >= d1) begin
                        r1 = r1 - d1;
                        a.quo[(K1 >= 0) ? K1 : 0] = 1'b1;
                    end
                end else begin
                    d1 = '0;
                end
                a.rem          = r1;
                st_next[3+gi]  = a;
            end
        end
    endgenerate

    // final rectangle selection
    stage_t               f;
    logic [CB-1:0]        s0, s1, s2, s3;
    logic signed [DW-1:0] d0v, d1v, d2v, d3v;
    logic signed [DW-1:0] siw, sih, ssw, ssh;
    logic signed [DW-1:0] cx, cy;
    logic [CB-1:0]        off;

    always_comb begin
        f   = st_reg[NS-1];
        siw = $signed(DW'(f.iw));
        sih = $signed(DW'(f.ih));
        ssw = $signed(DW'(f.sw));
        ssh = $signed(DW'(f.sh));
        cx  = DW'((ssw - siw) / 2);
        cy  = DW'((ssh - sih) / 2);
        if (f.dz) begin
            off = '0;
        end else if (f.taller) begin
            off = (f.ih - f.quo) >> 1;
        end else begin
            off = (f.iw - f.quo) >> 1;
        end
        s0  = '0;
        s1  = '0;
        s2  = f.iw;
        s3  = f.ih;
        d0v = '0;
        d1v = '0;
        d2v = ssw;
        d3v = ssh;
        unique case (f.mode)
            MODE_CENTER, MODE_FIT: begin
                if (f.taller && f.ih > f.sh) begin
                    s1  = (f.ih - f.sh) >> 1;
                    s3  = f.ih - s1;
                    d0v = cx;
                    d2v = ssw - cx;
                end else if (!f.taller && f.iw > f.sw) begin
                    s0  = (f.iw - f.sw) >> 1;
                    s2  = f.iw - s0;
                    d1v = cy;
                    d3v = ssh - cy;
                end else begin
                    d0v = cx;
                    d2v = ssw - cx;
                    d1v = cy;
                    d3v = ssh - cy;
                end
            end
            MODE_TILE: begin
                if (f.taller) begin
                    if (f.iw > f.sw) begin
                        s2 = f.sw;
                        s3 = f.sh;
                    end else if (f.ih > f.sh) begin
                        s3 = f.sh;
                    end
                end else begin
                    if (f.ih > f.sh) begin
                        s2 = f.sw;
                        s3 = f.sh;
                    end else if (f.iw > f.sw) begin
                        s2 = f.sw;
                    end
                end
            end
            MODE_STRETCH: begin
                s2 = '0;
                s3 = '0;
            end
            MODE_FILL: begin
                if (f.taller) begin
                    s1 = off;
                    s3 = f.ih - off;
                end else begin
                    s0 = off;
                    s2 = f.iw - off;
                end
            end
            default: begin
                s0 = '0;
            end
        endcase
        m_data_next = {d3v, d2v, d1v, d0v, s3, s2, s1, s0};
    end

    generate
        for (gi = 0; gi < NS; gi++) begin : g_stage
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[gi] <= 1'b0;
                end else if (en[gi]) begin
                    vld_reg[gi] <= (gi == 0) ? s_tvalid : vld_reg[(gi == 0) ? 0 : gi-1];
                end
            end
            always_ff @(posedge aclk) begin
                if (en[gi]) begin
                    st_reg[gi] <= st_next[gi];
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_en) begin
            m_valid_reg <= vld_reg[NS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en && vld_reg[NS-1]) begin
            m_data_reg <= m_data_next;
        end
    end

    // an empty output register frees every stage behind it
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready) else $error("input stalled with empty output");

    a_ready_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready) else $error("input stalled while output drains");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid) else $error("output valid after reset");

    a_src_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[CB-1:0] <= m_tdata[3*CB-1:2*CB] || m_tdata[3*CB-1:2*CB] == '0))
        else $error("crop left edge past right edge");

endmodule
